// ----- hdl/cls_pkg.sv -----
// Package for the command line splitter: byte codes, counter limits and the
// result beat structure. No dependencies; every other file imports it.
package cls_pkg;

    localparam int MAX_SLASH_RUN = 255;
    localparam int MAX_ARGS      = 255;
    localparam int MAX_CHARS     = 65535;

    // At this limit the backslash counter steps back, keeping its parity true.
    localparam logic [8:0]  BS_LIMIT     = 9'(2 * MAX_SLASH_RUN + 1);
    localparam logic [7:0]  RUN_LIMIT    = 8'(MAX_SLASH_RUN);
    localparam logic [7:0]  ARG_LIMIT    = 8'(MAX_ARGS);
    localparam logic [15:0] CHAR_LIMIT   = 16'(MAX_CHARS);

    localparam logic [7:0]  CH_NUL       = 8'h00;
    localparam logic [7:0]  CH_TAB       = 8'h09;
    localparam logic [7:0]  CH_SPACE     = 8'h20;
    localparam logic [7:0]  CH_QUOTE     = 8'h22;
    localparam logic [7:0]  CH_BACKSLASH = 8'h5C;

    typedef struct packed {
        logic [7:0]  slash_run;
        logic        byte_valid;
        logic [7:0]  out_byte;
        logic        arg_end;
        logic [7:0]  arg_number;
        logic        line_done;
        logic [7:0]  arg_total;
        logic [15:0] char_total;
    } t_result;

endpackage

// ----- hdl/command_line_splitter.sv -----
// Command line splitter: one command line byte per beat in, one result beat
// for each byte that produces output. An accepted byte is held in the input register, goes
// through the combinational parser step and is loaded into the output register; throughput
// is one byte per cycle while the output register can pass its beat on.
// Bytes that produce nothing (separators between arguments, backslashes, bare quotes) are absorbed.
// Synchronous active-low reset clears the parser to line start and empties both registers.
module command_line_splitter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] in_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] slash_run, [15:8] out_byte, [23:16] arg_number, [31:24] arg_total,
    // [47:32] char_total
    output logic [47:0] o_m_axis_tdata,
    output logic [1:0]  o_m_axis_tuser,   // [0] byte_valid, [1] arg_end
    output logic        o_m_axis_tlast    // line_done
);
    import cls_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       fire;
    logic       emit;
    t_result    step_res;
    t_result    out_res;

    // The parser advances whenever a byte is held and the output register can take a beat.
    assign fire            = r_in_valid && (!o_m_axis_tvalid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    cls_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .o_emit  (emit),
        .o_res   (step_res)
    );

    cls_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire && emit),
        .i_res   (step_res),
        .i_ready (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_res   (out_res)
    );

    assign o_m_axis_tdata = {out_res.char_total, out_res.arg_total, out_res.arg_number,
                             out_res.out_byte, out_res.slash_run};
    assign o_m_axis_tuser = {out_res.arg_end, out_res.byte_valid};
    assign o_m_axis_tlast = out_res.line_done;

endmodule

// ----- hdl/cls_parse.sv -----
// Parser state and the per-byte step logic of the command line splitter.
// Depends on cls_pkg for byte codes, limits and the result structure.
module cls_parse (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_byte,
    output logic             o_emit,
    output cls_pkg::t_result o_res
);
    import cls_pkg::*;

    typedef enum logic [2:0] {
        PH_START       = 3'd0,
        PH_PROG_QUOTED = 3'd1,
        PH_PROG_PLAIN  = 3'd2,
        PH_BETWEEN     = 3'd3,
        PH_IN_ARG      = 3'd4
    } t_phase;

    t_phase      r_phase, n_phase;
    logic        r_in_quotes, n_in_quotes;
    logic        r_quote_pending, n_quote_pending;
    logic [8:0]  r_bs_cnt, n_bs_cnt;
    logic [7:0]  r_arg_idx, n_arg_idx;
    logic [15:0] r_byte_cnt, n_byte_cnt;

    logic        v_sep;
    logic        v_go;
    logic        v_done;
    logic        v_valid;
    logic        v_aend;
    logic [7:0]  v_run;
    logic [8:0]  v_add;
    logic [16:0] v_sum;
    logic [8:0]  v_tot;

    assign v_sep = (i_byte == CH_SPACE) || (i_byte == CH_TAB);

    always_comb begin
        n_phase         = r_phase;
        n_in_quotes     = r_in_quotes;
        n_quote_pending = r_quote_pending;
        n_bs_cnt        = r_bs_cnt;
        n_arg_idx       = r_arg_idx;
        n_byte_cnt      = r_byte_cnt;
        o_emit          = 1'b0;
        o_res           = '0;
        o_res.arg_number = r_arg_idx;
        v_go            = 1'b0;
        v_done          = 1'b0;
        v_valid         = 1'b0;
        v_aend          = 1'b0;
        v_run           = '0;
        v_add           = '0;

        unique case (r_phase)
            PH_PROG_QUOTED: begin
                o_emit = 1'b1;
                v_add  = 9'd1;
                if (i_byte == CH_QUOTE || i_byte == CH_NUL) begin
                    v_aend  = 1'b1;
                    v_done  = (i_byte == CH_NUL);
                    n_phase = PH_BETWEEN;
                end else begin
                    v_valid = 1'b1;
                end
            end
            PH_BETWEEN, PH_IN_ARG: begin
                v_go = 1'b1;
                if (r_phase == PH_BETWEEN) begin
                    if (v_sep) begin
                        v_go = 1'b0;
                    end else if (i_byte == CH_NUL) begin
                        // Line ends between arguments: only the totals go out.
                        v_go   = 1'b0;
                        o_emit = 1'b1;
                        v_done = 1'b1;
                    end else begin
                        if (r_arg_idx < ARG_LIMIT) begin
                            n_arg_idx = r_arg_idx + 8'd1;
                        end
                        o_res.arg_number = n_arg_idx;
                        n_phase = PH_IN_ARG;
                    end
                end
                if (v_go) begin
                    if (r_quote_pending && i_byte == CH_QUOTE) begin
                        // Second quote of a doubled pair inside quotes.
                        n_quote_pending = 1'b0;
                        v_add   = 9'd1;
                        v_valid = 1'b1;
                        o_emit  = 1'b1;
                    end else if (i_byte == CH_BACKSLASH) begin
                        n_quote_pending = 1'b0;
                        if (r_bs_cnt >= BS_LIMIT) begin
                            n_bs_cnt = r_bs_cnt - 9'd1;
                        end else begin
                            n_bs_cnt = r_bs_cnt + 9'd1;
                        end
                    end else begin
                        n_quote_pending = 1'b0;
                        n_bs_cnt        = '0;
                        if (i_byte == CH_QUOTE) begin
                            v_run = r_bs_cnt[8:1];
                            if (!r_bs_cnt[0]) begin
                                if (r_in_quotes) begin
                                    n_in_quotes     = 1'b0;
                                    n_quote_pending = 1'b1;
                                end else begin
                                    n_in_quotes = 1'b1;
                                end
                            end else begin
                                v_valid = 1'b1;
                            end
                        end else begin
                            v_run = (r_bs_cnt > 9'(RUN_LIMIT)) ? RUN_LIMIT : r_bs_cnt[7:0];
                            if (i_byte == CH_NUL) begin
                                v_aend = 1'b1;
                                v_done = 1'b1;
                            end else if (!r_in_quotes && v_sep) begin
                                v_aend  = 1'b1;
                                n_phase = PH_BETWEEN;
                            end else begin
                                v_valid = 1'b1;
                            end
                        end
                        v_add  = {1'b0, v_run} + {8'd0, v_valid} + {8'd0, v_aend};
                        o_emit = (v_run != 8'd0) || v_valid || v_aend;
                    end
                end
            end
            default: begin
                if (r_phase != PH_PROG_PLAIN && i_byte == CH_QUOTE) begin
                    n_phase = PH_PROG_QUOTED;
                end else begin
                    o_emit = 1'b1;
                    v_add  = 9'd1;
                    if (i_byte == CH_NUL || v_sep) begin
                        v_aend  = 1'b1;
                        v_done  = (i_byte == CH_NUL);
                        n_phase = PH_BETWEEN;
                    end else begin
                        v_valid = 1'b1;
                        n_phase = PH_PROG_PLAIN;
                    end
                end
            end
        endcase

        v_sum = {1'b0, r_byte_cnt} + {8'd0, v_add};
        n_byte_cnt = (v_sum >= {1'b0, CHAR_LIMIT}) ? CHAR_LIMIT : v_sum[15:0];
        v_tot = {1'b0, n_arg_idx} + 9'd2;

        o_res.slash_run  = v_run;
        o_res.byte_valid = v_valid;
        o_res.out_byte   = v_valid ? i_byte : 8'd0;
        o_res.arg_end    = v_aend;
        o_res.line_done  = v_done;
        if (v_done) begin
            o_res.arg_total  = (v_tot > {1'b0, ARG_LIMIT}) ? ARG_LIMIT : v_tot[7:0];
            o_res.char_total = n_byte_cnt;
            n_phase         = PH_START;
            n_in_quotes     = 1'b0;
            n_quote_pending = 1'b0;
            n_bs_cnt        = '0;
            n_arg_idx       = '0;
            n_byte_cnt      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_START;
            r_in_quotes     <= 1'b0;
            r_quote_pending <= 1'b0;
            r_bs_cnt        <= '0;
            r_arg_idx       <= '0;
            r_byte_cnt      <= '0;
        end else if (i_fire) begin
            r_phase         <= n_phase;
            r_in_quotes     <= n_in_quotes;
            r_quote_pending <= n_quote_pending;
            r_bs_cnt        <= n_bs_cnt;
            r_arg_idx       <= n_arg_idx;
            r_byte_cnt      <= n_byte_cnt;
        end
    end

    // A finished line leaves the counters cleared for the next one.
    a_line_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_emit && o_res.line_done) |=>
            (r_phase == PH_START && r_arg_idx == 8'd0 && r_byte_cnt == 16'd0))
        else $error("line end did not clear parser state");

    // Backslashes are only ever counted inside an argument after the name.
    a_bs_in_arg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bs_cnt != 9'd0) |-> (r_phase == PH_IN_ARG))
        else $error("backslash run held outside an argument");

    // A pending doubled quote only arises as quoting has just closed.
    a_pending_unquoted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_quote_pending |-> !r_in_quotes)
        else $error("quote pending while still inside quotes");

    a_byte_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit && !o_res.byte_valid) |-> (o_res.out_byte == 8'd0))
        else $error("out_byte not zero on a beat without a byte");

endmodule

// ----- hdl/cls_out_reg.sv -----
// Output register of the command line splitter, holding one result beat.
// Depends on cls_pkg for the result structure.
module cls_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  cls_pkg::t_result i_res,
    input  logic             i_ready,
    output logic             o_valid,
    output cls_pkg::t_result o_res
);
    import cls_pkg::*;

    logic    r_valid;
    t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule
